/* hw/rtl/srrw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective-repeat receiver window package
// Shared types and constants for the receiver window front, back and top.
// ----------------------------------------------------------------------------
package srrw_pkg;

  localparam int unsigned SeqFieldW  = 6;
  localparam int unsigned WinFieldW  = 6;
  localparam logic [WinFieldW-1:0] WinSizeReset = 6'd4;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_DONE
  } back_state_t;

  // One result as shown on the result ports.
  typedef struct packed {
    logic                 done;
    logic                 accepted;
    logic [SeqFieldW-1:0] next_expected;
  } result_t;

endpackage

/* hw/rtl/srrw_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receiver window classification queue
// Two-entry FIFO that carries classified frames from the front to the back.
// ----------------------------------------------------------------------------
module srrw_queue #(
  parameter int unsigned DATA_W = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] head_data,
  output logic              empty,
  output logic              full
);

  logic [DATA_W-1:0] entries [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  assign empty     = (count == 2'd0);
  assign full      = (count == 2'd2);
  assign head_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hw/rtl/srrw_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receiver window front end
// Holds the window size register and classifies each arriving frame against
// the current window, producing the accept flag and the slot offset.
// ----------------------------------------------------------------------------
module srrw_front #(
  parameter int unsigned SEQ_SPACE = 64
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_valid,
  input  logic [srrw_pkg::WinFieldW-1:0]             cfg_data,
  input  logic [srrw_pkg::SeqFieldW-1:0]             frame_seq,
  input  logic [$clog2(SEQ_SPACE)-1:0]               window_left,
  output logic                                       class_ok,
  output logic [$clog2(((SEQ_SPACE/2) < 63) ? (SEQ_SPACE/2) : 63)-1:0] class_off
);

  import srrw_pkg::*;

  localparam int unsigned LeftW = $clog2(SEQ_SPACE);
  localparam int unsigned Half  = SEQ_SPACE / 2;
  localparam int unsigned MarkW = (Half < 63) ? Half : 63;
  localparam int unsigned OffW  = $clog2(MarkW);
  localparam int unsigned CmpW  = LeftW + 7;

  logic [WinFieldW-1:0] window_size;
  logic [CmpW-1:0]      seq_wide;
  logic [CmpW-1:0]      win_wide;
  logic                 in_space;
  logic [LeftW-1:0]     seq_l;
  logic [LeftW:0]       diff;
  logic [LeftW-1:0]     offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WinSizeReset;
    end else if (cfg_valid) begin
      window_size <= cfg_data;
    end
  end

  always_comb begin
    seq_wide = CmpW'(frame_seq);
    in_space = (seq_wide < CmpW'(SEQ_SPACE));
    seq_l    = seq_wide[LeftW-1:0];
    // Distance from the left edge, taken around the sequence space.
    diff = {1'b0, seq_l} - {1'b0, window_left};
    if (seq_l < window_left) begin
      diff = diff + (LeftW+1)'(SEQ_SPACE);
    end
    offset = diff[LeftW-1:0];
    // A window wider than half the space would confuse old and new numbers.
    if (CmpW'(window_size) > CmpW'(Half)) begin
      win_wide = CmpW'(Half);
    end else begin
      win_wide = CmpW'(window_size);
    end
    class_ok  = in_space && (CmpW'(offset) < win_wide);
    class_off = offset[OffW-1:0];
  end

endmodule

/* hw/rtl/srrw_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receiver window back end
// Marks accepted slots and slides the left edge over consecutive marks,
// up to four slots per cycle, then presents the result for one cycle.
// ----------------------------------------------------------------------------
module srrw_back #(
  parameter int unsigned SEQ_SPACE = 64
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       q_empty,
  input  logic                                       q_ok,
  input  logic [$clog2(((SEQ_SPACE/2) < 63) ? (SEQ_SPACE/2) : 63)-1:0] q_off,
  output logic                                       q_pop,
  output logic                                       back_busy,
  output logic [$clog2(SEQ_SPACE)-1:0]               window_left,
  output srrw_pkg::result_t                          result
);

  import srrw_pkg::*;

  localparam int unsigned LeftW = $clog2(SEQ_SPACE);
  localparam int unsigned Half  = SEQ_SPACE / 2;
  localparam int unsigned MarkW = (Half < 63) ? Half : 63;
  localparam int unsigned OffW  = $clog2(MarkW);
  localparam int unsigned Step  = (MarkW < 4) ? MarkW : 4;
  localparam int unsigned StepW = $clog2(Step + 1);

  back_state_t      state;
  back_state_t      state_next;
  // Marks held relative to the left edge: bit k is slot window_left + k.
  logic [MarkW-1:0] marks;
  logic             cur_ok;
  logic [StepW-1:0] run_len;
  logic             run_on;
  logic [LeftW:0]   left_sum;
  logic [LeftW-1:0] left_adv;
  logic             scan_end;
  logic [SeqFieldW+LeftW-1:0] left_ext;

  always_comb begin
    run_len = '0;
    run_on  = 1'b1;
    for (int i = 0; i < Step; i++) begin
      if (run_on && marks[i]) begin
        run_len = run_len + StepW'(1);
      end else begin
        run_on = 1'b0;
      end
    end
    left_sum = {1'b0, window_left} + (LeftW+1)'(run_len);
    if (left_sum >= (LeftW+1)'(SEQ_SPACE)) begin
      left_sum = left_sum - (LeftW+1)'(SEQ_SPACE);
    end
    left_adv = left_sum[LeftW-1:0];
    scan_end = (run_len != StepW'(Step));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          state_next = q_ok ? B_SCAN : B_DONE;
        end
      end
      B_SCAN: begin
        if (scan_end) begin
          state_next = B_DONE;
        end
      end
      B_DONE:  state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = 1'b0;
    back_busy = 1'b1;
    unique case (state)
      B_IDLE: begin
        q_pop     = !q_empty;
        back_busy = 1'b0;
      end
      B_SCAN:  back_busy = 1'b1;
      B_DONE:  back_busy = 1'b1;
      default: back_busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      marks       <= '0;
      window_left <= '0;
      cur_ok      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_IDLE && !q_empty) begin
        cur_ok <= q_ok;
        if (q_ok) begin
          for (int i = 0; i < MarkW; i++) begin
            if (OffW'(i) == q_off) begin
              marks[i] <= 1'b1;
            end
          end
        end
      end else if (state == B_SCAN) begin
        marks       <= marks >> run_len;
        window_left <= left_adv;
      end
    end
  end

  assign left_ext = {{SeqFieldW{1'b0}}, window_left};

  assign result.done          = (state == B_DONE);
  assign result.accepted      = cur_ok;
  assign result.next_expected = left_ext[SeqFieldW-1:0];

endmodule

/* hw/rtl/selective_repeat_receiver_window_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective-repeat receiver window
// A frame taken on start is queued, popped by the back end when idle, and its
// result is shown in the done state; an accepted frame first passes the scan.
// The edge scan retires up to four marks per cycle; busy stays high through the
// result strobe, so a new frame is taken only once the last one's result is out.
// Reset clears all marks, the left edge to zero and the window size to 4.
// ----------------------------------------------------------------------------
module selective_repeat_receiver_window_top #(
  parameter int unsigned SEQ_SPACE = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [srrw_pkg::SeqFieldW-1:0] frame_seq,
  output logic                           done,
  output logic                           accepted,
  output logic [srrw_pkg::SeqFieldW-1:0] next_expected,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [srrw_pkg::WinFieldW-1:0] cfg_data
);

  import srrw_pkg::*;

  localparam int unsigned LeftW = $clog2(SEQ_SPACE);
  localparam int unsigned Half  = SEQ_SPACE / 2;
  localparam int unsigned MarkW = (Half < 63) ? Half : 63;
  localparam int unsigned OffW  = $clog2(MarkW);

  logic             class_ok;
  logic [OffW-1:0]  class_off;
  logic [LeftW-1:0] window_left;
  logic             q_push;
  logic             q_pop;
  logic             q_empty;
  logic             q_full;
  logic [OffW:0]    q_head;
  logic             back_busy;
  result_t          result;

  assign cfg_ready = 1'b1;
  assign busy      = !q_empty || back_busy;
  assign q_push    = start && !busy;

  srrw_front #(.SEQ_SPACE(SEQ_SPACE)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .frame_seq   (frame_seq),
    .window_left (window_left),
    .class_ok    (class_ok),
    .class_off   (class_off)
  );

  srrw_queue #(.DATA_W(OffW + 1)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({class_ok, class_off}),
    .pop       (q_pop),
    .head_data (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  srrw_back #(.SEQ_SPACE(SEQ_SPACE)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_ok        (q_head[OffW]),
    .q_off       (q_head[OffW-1:0]),
    .q_pop       (q_pop),
    .back_busy   (back_busy),
    .window_left (window_left),
    .result      (result)
  );

  // The queue never fills because busy holds off start while an item is open.
  assign done          = result.done && !q_full;
  assign accepted      = result.accepted;
  assign next_expected = result.next_expected;

endmodule

/* hw/rtl/srrw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receiver window port checker
// Watches the top-level ports for handshake and result-timing slips.
// ----------------------------------------------------------------------------
module srrw_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk) rst |=> !busy && !done)
    else $error("block not idle after reset");

  // A frame taken in makes the block busy and gives no result in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted frame did not hold the block busy");

  // A result is shown while its frame still holds the block.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while idle");

  // A result strobe is high for a single cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

bind selective_repeat_receiver_window_top srrw_checker u_srrw_checker (.*);

/* dv/srrw_window_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Receiver window checker
// Watches the frame, result and window-size channels of the selective-repeat
// receiver window. It keeps its own window edge, receive marks and window
// size, predicts the acknowledgement for every frame transfer and compares
// each result strobe, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module srrw_window_checker #(
  parameter int unsigned SEQ_SPACE = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic [srrw_pkg::SeqFieldW-1:0] frame_seq,
  input  logic                           done,
  input  logic                           accepted,
  input  logic [srrw_pkg::SeqFieldW-1:0] next_expected,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [srrw_pkg::WinFieldW-1:0] cfg_data,
  output int                             fault_count,
  output int                             open_acks
);

  typedef struct packed {
    logic                           ok;
    logic [srrw_pkg::SeqFieldW-1:0] ack;
  } frame_ack_t;

  frame_ack_t                     expected_acks[$];
  logic [SEQ_SPACE-1:0]           rx_marks;
  int unsigned                    left_edge;
  logic [srrw_pkg::WinFieldW-1:0] win_size;
  int                             faults;

  always @(posedge clk) begin : predict_and_compare
    int unsigned offset;
    int unsigned span;
    int unsigned n;
    frame_ack_t  pred;
    frame_ack_t  want;

    if (rst) begin
      rx_marks  = '0;
      left_edge = 0;
      win_size  = srrw_pkg::WinSizeReset;
      faults    = 0;
      expected_acks.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        win_size = cfg_data;
      end

      if (start && !busy) begin
        // Windows wider than half the sequence space are clamped to half.
        span = (win_size > SEQ_SPACE / 2) ? SEQ_SPACE / 2 : win_size;
        pred.ok = 1'b0;
        if (frame_seq < SEQ_SPACE) begin
          offset = (frame_seq + SEQ_SPACE - left_edge) % SEQ_SPACE;
          if (offset < span) begin
            pred.ok = 1'b1;
            rx_marks[frame_seq] = 1'b1;
          end
        end
        if (pred.ok) begin
          for (n = 0; n < SEQ_SPACE && rx_marks[left_edge]; n++) begin
            rx_marks[left_edge] = 1'b0;
            left_edge = (left_edge + 1) % SEQ_SPACE;
          end
        end
        pred.ack = left_edge[srrw_pkg::SeqFieldW-1:0];
        expected_acks.push_back(pred);
      end

      if (done) begin
        if (expected_acks.size() == 0) begin
          $display("%0t: result with no frame outstanding (accepted %0b, next_expected %0d)",
                   $time, accepted, next_expected);
          faults++;
        end else begin
          want = expected_acks.pop_front();
          if (accepted !== want.ok) begin
            $display("%0t: accepted mismatch, expected %0b actual %0b",
                     $time, want.ok, accepted);
            faults++;
          end
          if (next_expected !== want.ack) begin
            $display("%0t: next_expected mismatch, expected %0d actual %0d",
                     $time, want.ack, next_expected);
            faults++;
          end
        end
      end
    end

    fault_count <= faults;
    open_acks   <= expected_acks.size();
  end

endmodule

/* dv/selective_repeat_receiver_window_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selective-repeat receiver window testbench
// Drives frame sequence numbers and window-size writes into the block: a
// directed part covering refused, duplicate, stale and out-of-window frames,
// the zero, clamped and shrunk windows, then random phases over several window
// sizes with random gaps. Checking is done by the checker instance.
// ----------------------------------------------------------------------------
module selective_repeat_receiver_window_top_tb;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           start     = 1'b0;
  logic [srrw_pkg::SeqFieldW-1:0] frame_seq = '0;
  logic                           cfg_valid = 1'b0;
  logic [srrw_pkg::WinFieldW-1:0] cfg_data  = '0;
  logic                           busy;
  logic                           done;
  logic                           accepted;
  logic [srrw_pkg::SeqFieldW-1:0] next_expected;
  logic                           cfg_ready;

  int                             fault_count;
  int                             open_acks;
  int                             win_cfg = srrw_pkg::WinSizeReset;
  logic [srrw_pkg::SeqFieldW-1:0] last_ack;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  selective_repeat_receiver_window_top u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .frame_seq     (frame_seq),
    .done          (done),
    .accepted      (accepted),
    .next_expected (next_expected),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  srrw_window_checker u_chk (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .frame_seq     (frame_seq),
    .done          (done),
    .accepted      (accepted),
    .next_expected (next_expected),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fault_count   (fault_count),
    .open_acks     (open_acks)
  );

  // The latest acknowledgement steers random frames toward the window.
  always @(posedge clk) begin
    if (rst) begin
      last_ack <= '0;
    end else if (done) begin
      last_ack <= next_expected;
    end
  end

  // Leaves start high after the transfer so that a zero gap keeps it asserted.
  task automatic send_frame(input logic [srrw_pkg::SeqFieldW-1:0] seq, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    frame_seq <= seq;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_acks();
    start <= 1'b0;
    @(posedge clk);
    while (open_acks != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_window(input logic [srrw_pkg::WinFieldW-1:0] size);
    drain_acks();
    cfg_valid <= 1'b1;
    cfg_data  <= size;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    win_cfg = size;
  endtask

  function automatic logic [srrw_pkg::SeqFieldW-1:0] pick_frame();
    int span;
    int r;
    span = (win_cfg > 32) ? 32 : win_cfg;
    r = $urandom_range(0, 9);
    if (span == 0 || r >= 8) begin
      return srrw_pkg::SeqFieldW'($urandom_range(0, 63));
    end
    if (r == 0) begin
      return last_ack;
    end
    return srrw_pkg::SeqFieldW'(last_ack + $urandom_range(0, span - 1));
  endfunction

  initial begin : stimulus
    logic [srrw_pkg::WinFieldW-1:0] phase_sizes[9];
    logic [srrw_pkg::SeqFieldW-1:0] directed[$];
    bit burst;
    int gap;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset window of four: edge move, stale frame, far edge of the window,
    // one past it, duplicate, then a frame that releases a run of marks.
    directed = '{6'd0, 6'd0, 6'd2, 6'd3, 6'd4, 6'd5, 6'd2, 6'd1, 6'd63, 6'd5};
    foreach (directed[i]) send_frame(directed[i], i % 3);

    // Empty window refuses everything.
    write_window(6'd0);
    send_frame(6'd6, 0);
    send_frame(6'd7, 1);

    // An oversized window acts as half the sequence space.
    write_window(6'd63);
    send_frame(6'd37, 0);
    send_frame(6'd38, 0);
    send_frame(6'd6, 2);

    // Marks left beyond a shrunk window are consumed when the edge reaches them.
    write_window(6'd32);
    send_frame(6'd9, 0);
    send_frame(6'd20, 0);
    write_window(6'd1);
    send_frame(6'd9, 0);
    send_frame(6'd8, 0);
    send_frame(6'd7, 0);

    phase_sizes = '{6'd1, 6'd32, 6'd63, 6'd0, 6'd2, 6'd33, 6'd31, 6'd16, 6'd4};
    phase_sizes[7] = srrw_pkg::WinFieldW'($urandom_range(1, 32));
    foreach (phase_sizes[p]) begin
      write_window(phase_sizes[p]);
      burst = ($urandom_range(0, 3) == 0);
      repeat (100) begin
        gap = burst ? 0 : $urandom_range(0, 16);
        send_frame(pick_frame(), gap);
      end
    end

    drain_acks();
    repeat (24) @(posedge clk);
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
